### hw/rtl/gbnsw_pkg.sv
// Shared types and constants for the go-back-n send window.
`default_nettype none

package gbnsw_pkg;

   localparam int unsigned SEQ_BITS_DEFAULT   = 16;
   localparam int unsigned WINDOW_MAX_DEFAULT = 16;

   localparam int unsigned WSIZE_BITS   = 5;
   localparam int unsigned TICK_BITS    = 16;
   localparam int unsigned CSR_IDX_BITS = 2;

   localparam logic [WSIZE_BITS-1:0] WINDOW_RESET  = 5'd16;
   localparam logic [TICK_BITS-1:0]  TIMEOUT_RESET = 16'd200;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_ACK   = 2'd1,
      OP_TICK  = 2'd2,
      OP_SLOT  = 2'd3
   } opcode_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_SEQ   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_END_SEQ     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SIZE = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT     = 2'd3;

endpackage

`default_nettype wire

### hw/rtl/go_back_n_send_window.sv
// Go-back-n sender window: one event beat in, one send decision beat out.
//
// Usage: drive req_opcode (start, ack, tick, transmit slot) with req_ack_number
// for acks on the req_ channel. Every accepted beat yields exactly one rsp_
// beat carrying send_valid/send_seq (the packet to put on the wire now),
// transfer_done and timed_out. rsp_valid rises in the cycle after accept;
// throughput is one event per cycle unless the receiver stalls, set by the
// single window-update pass (one add, compare and clamp) between the event
// and the result register. The result register acts as the output stage:
// req_ready stays high while it is empty or being drained, so a stalled
// receiver holds one result and blocks further events until it is taken.
// The csr_ port writes first_seq, end_seq, window_size and timeout_ticks;
// write only while no beat is outstanding.
// Synchronous reset restores register defaults (window 16, timeout 200),
// empties the output stage and leaves the window inactive until a start.
`default_nettype none

module go_back_n_send_window #(
   parameter int unsigned SEQ_BITS   = gbnsw_pkg::SEQ_BITS_DEFAULT,
   parameter int unsigned WINDOW_MAX = gbnsw_pkg::WINDOW_MAX_DEFAULT,
   localparam int unsigned CSR_BITS  = (SEQ_BITS > 16) ? SEQ_BITS : 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_opcode,
   input  wire logic [SEQ_BITS-1:0]                 req_ack_number,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_send_valid,
   output logic [SEQ_BITS-1:0]                      rsp_send_seq,
   output logic                                     rsp_transfer_done,
   output logic                                     rsp_timed_out,
   input  wire logic                                csr_write,
   input  wire logic [gbnsw_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_BITS-1:0]                 csr_wdata
);

   localparam int unsigned TB = gbnsw_pkg::TICK_BITS;
   localparam int unsigned WB = gbnsw_pkg::WSIZE_BITS;
   localparam logic [8:0]  WIN_MAX_V = 9'(WINDOW_MAX);

   // configuration
   logic [SEQ_BITS-1:0] first_seq_ff, end_seq_ff;
   logic [WB-1:0]       window_size_ff;
   logic [TB-1:0]       timeout_ff;

   // window state
   logic [SEQ_BITS-1:0] win_start_ff, win_start_in;
   logic [SEQ_BITS-1:0] win_end_ff, win_end_in;
   logic [SEQ_BITS-1:0] next_ff, next_in;
   logic [SEQ_BITS-1:0] largest_ff, largest_in;
   logic                rewind_ff, rewind_in;
   logic [TB-1:0]       idle_ff, idle_in;
   logic                active_ff, active_in;
   logic                finished_ff, finished_in;

   // output stage
   logic                rsp_valid_ff;
   logic                send_valid_ff, send_valid_in;
   logic [SEQ_BITS-1:0] send_seq_ff, send_seq_in;
   logic                done_ff;
   logic                tmo_ff, tmo_in;

   logic                req_fire;
   gbnsw_pkg::opcode_type op;

   logic [8:0]          win_eff;
   logic [SEQ_BITS-1:0] clamp_base, clamp_end;
   logic [SEQ_BITS:0]   end_sum;
   logic [SEQ_BITS-1:0] advance;
   logic [TB-1:0]       tick_inc, tick_lim;
   logic [SEQ_BITS-1:0] slot_seq;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign op        = gbnsw_pkg::opcode_type'(req_opcode);

   // effective window, clamped to one..WINDOW_MAX
   always_comb begin
      priority if (window_size_ff == '0) begin
         win_eff = 9'd1;
      end else if ({4'd0, window_size_ff} > WIN_MAX_V) begin
         win_eff = WIN_MAX_V;
      end else begin
         win_eff = {4'd0, window_size_ff};
      end
   end

   // one shared clamp: start opens at first_seq, an ack slides to the ack
   assign clamp_base = (op == gbnsw_pkg::OP_START) ? first_seq_ff : req_ack_number;
   assign end_sum    = {1'b0, clamp_base} + (SEQ_BITS+1)'(win_eff);
   assign clamp_end  = (end_sum >= {1'b0, end_seq_ff}) ? end_seq_ff
                                                       : end_sum[SEQ_BITS-1:0];
   assign advance    = req_ack_number - win_start_ff;

   assign tick_inc = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
   assign tick_lim = (timeout_ff == '0) ? TB'(1) : timeout_ff;

   always_comb begin
      win_start_in  = win_start_ff;
      win_end_in    = win_end_ff;
      next_in       = next_ff;
      largest_in    = largest_ff;
      rewind_in     = rewind_ff;
      idle_in       = idle_ff;
      active_in     = active_ff;
      finished_in   = finished_ff;
      send_valid_in = 1'b0;
      send_seq_in   = '0;
      tmo_in        = 1'b0;
      slot_seq      = rewind_ff ? win_start_ff : next_ff;
      if (slot_seq < win_start_ff) begin
         slot_seq = win_start_ff;
      end

      unique case (op)
         gbnsw_pkg::OP_START: begin
            win_start_in = first_seq_ff;
            win_end_in   = clamp_end;
            next_in      = first_seq_ff;
            largest_in   = '0;
            rewind_in    = 1'b1;
            idle_in      = '0;
            active_in    = 1'b1;
            finished_in  = 1'b0;
         end
         gbnsw_pkg::OP_ACK: begin
            if (active_ff && req_ack_number > win_start_ff) begin
               if (req_ack_number >= end_seq_ff) begin
                  finished_in = 1'b1;
                  active_in   = 1'b0;
               end else begin
                  win_start_in = req_ack_number;
                  win_end_in   = clamp_end;
                  // a shrinking slide means a loss: rewind at the next slot
                  if (advance >= largest_ff) begin
                     largest_in = advance;
                  end else begin
                     rewind_in = 1'b1;
                  end
                  idle_in = '0;
               end
            end
         end
         gbnsw_pkg::OP_TICK: begin
            if (active_ff) begin
               if (tick_inc >= tick_lim) begin
                  tmo_in    = 1'b1;
                  rewind_in = 1'b1;
                  idle_in   = '0;
               end else begin
                  idle_in = tick_inc;
               end
            end
         end
         gbnsw_pkg::OP_SLOT: begin
            if (active_ff) begin
               rewind_in = 1'b0;
               next_in   = slot_seq;
               if (slot_seq < win_end_ff && slot_seq < end_seq_ff) begin
                  send_valid_in = 1'b1;
                  send_seq_in   = slot_seq;
                  next_in       = slot_seq + 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_seq_ff   <= '0;
         end_seq_ff     <= '0;
         window_size_ff <= gbnsw_pkg::WINDOW_RESET;
         timeout_ff     <= gbnsw_pkg::TIMEOUT_RESET;
         win_start_ff   <= '0;
         win_end_ff     <= '0;
         next_ff        <= '0;
         largest_ff     <= '0;
         rewind_ff      <= 1'b1;
         idle_ff        <= '0;
         active_ff      <= 1'b0;
         finished_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               gbnsw_pkg::CSR_FIRST_SEQ:   first_seq_ff   <= csr_wdata[SEQ_BITS-1:0];
               gbnsw_pkg::CSR_END_SEQ:     end_seq_ff     <= csr_wdata[SEQ_BITS-1:0];
               gbnsw_pkg::CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[WB-1:0];
               gbnsw_pkg::CSR_TIMEOUT:     timeout_ff     <= csr_wdata[TB-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            win_start_ff <= win_start_in;
            win_end_ff   <= win_end_in;
            next_ff      <= next_in;
            largest_ff   <= largest_in;
            rewind_ff    <= rewind_in;
            idle_ff      <= idle_in;
            active_ff    <= active_in;
            finished_ff  <= finished_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         send_valid_ff <= send_valid_in;
         send_seq_ff   <= send_seq_in;
         done_ff       <= finished_in;
         tmo_ff        <= tmo_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_valid    = send_valid_ff;
   assign rsp_send_seq      = send_seq_ff;
   assign rsp_transfer_done = done_ff;
   assign rsp_timed_out     = tmo_ff;

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      req_fire && op == gbnsw_pkg::OP_START |=> active_ff && !finished_ff && rewind_ff)
      else $error("start did not open the window");

   a_active_xor_done: assert property (@(posedge clock) disable iff (reset)
      !(active_ff && finished_ff))
      else $error("window active after transfer finished");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid)
      else $error("accepted beat produced no result");

   a_send_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_valid |-> !rsp_transfer_done)
      else $error("packet sent after transfer finished");

   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && tmo_in |=> idle_ff == '0 && rewind_ff)
      else $error("timeout did not clear idle counter");

endmodule

`default_nettype wire
